/* rtl/url_query_percent_decoder_top_defines.svh */
// Assertion macros shared by the checker of the URL query percent decoder.
`ifndef URL_QUERY_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_QUERY_PERCENT_DECODER_TOP_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define UQPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that must also hold while reset is asserted.
`define UQPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/uqpd_pkg.sv */
// Package of the URL query percent decoder: constants, bundle type, hex helpers.
package uqpd_pkg;

  localparam logic [7:0]  CH_PLUS     = 8'h2B;
  localparam logic [7:0]  CH_PERCENT  = 8'h25;
  localparam logic [7:0]  CH_AMP      = 8'h26;
  localparam logic [7:0]  CH_QUESTION = 8'h3F;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [3:0]  HEX_ALPHA_BASE = 4'd10;
  localparam logic [15:0] ARGS_MAX    = 16'hFFFF;
  localparam logic [15:0] ARGS_INIT   = 16'd1;

  // Up to three words come from one input byte.
  localparam int SLOTS   = 3;
  localparam int SLOT_W  = 2;

  // Bundle queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } esc_phase_t;

  // All words that one input byte produces.
  typedef struct packed {
    logic [SLOT_W-1:0]     cnt;
    logic [SLOTS-1:0][7:0] bytes;
    logic [SLOTS-1:0]      sep;
    logic                  last;
    logic [15:0]           args;
  } res_bundle_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + {4'h0, HEX_ALPHA_BASE};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + {4'h0, HEX_ALPHA_BASE};
    end
    return d[3:0];
  endfunction

endpackage

/* rtl/uqpd_front.sv */
// Front end: classify each byte, track escape state and argument count, build a bundle.
module uqpd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  accept,
  output uqpd_pkg::res_bundle_t bnd,
  output logic                  bnd_vld
);

  uqpd_pkg::esc_phase_t phase_r, phase_nxt, phase_mid;
  logic [7:0]  held_r, held_nxt, held_mid;
  logic [15:0] args_r, args_nxt, args_mid;

  logic       byte_hex;
  logic       plain;
  logic       pre_pct, pre_dig;
  logic       main_vld, main_sep;
  logic [7:0] main_byte;
  logic       inc;
  logic       flush_pct, flush_dig;
  logic [uqpd_pkg::SLOT_W-1:0] n;

  assign byte_hex = uqpd_pkg::is_hex(in_byte);

  // Escape handling ahead of the plain byte path.
  always_comb begin
    phase_mid = uqpd_pkg::PH_IDLE;
    held_mid  = held_r;
    plain     = 1'b0;
    pre_pct   = 1'b0;
    pre_dig   = 1'b0;
    main_vld  = 1'b0;
    main_sep  = 1'b0;
    main_byte = 8'h00;
    inc       = 1'b0;
    case (phase_r)
      uqpd_pkg::PH_PCT: begin
        if (byte_hex) begin
          phase_mid = uqpd_pkg::PH_DIGIT;
          held_mid  = in_byte;
        end else begin
          pre_pct = 1'b1;
          plain   = 1'b1;
        end
      end
      uqpd_pkg::PH_DIGIT: begin
        if (byte_hex) begin
          main_vld  = 1'b1;
          main_byte = {uqpd_pkg::hex_val(held_r), uqpd_pkg::hex_val(in_byte)};
        end else begin
          pre_pct = 1'b1;
          pre_dig = 1'b1;
          plain   = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      if (in_byte == uqpd_pkg::CH_PERCENT) begin
        phase_mid = uqpd_pkg::PH_PCT;
      end else if (in_byte == uqpd_pkg::CH_PLUS) begin
        main_vld  = 1'b1;
        main_byte = uqpd_pkg::CH_SPACE;
      end else if (in_byte == uqpd_pkg::CH_AMP || in_byte == uqpd_pkg::CH_QUESTION) begin
        main_vld = 1'b1;
        main_sep = 1'b1;
        inc      = 1'b1;
      end else begin
        main_vld  = 1'b1;
        main_byte = in_byte;
      end
    end
  end

  assign args_mid  = (inc && args_r != uqpd_pkg::ARGS_MAX) ? args_r + 16'd1 : args_r;
  assign flush_pct = in_last && (phase_mid != uqpd_pkg::PH_IDLE);
  assign flush_dig = in_last && (phase_mid == uqpd_pkg::PH_DIGIT);

  // Pack words in order: held escape, main byte, end-of-string flush.
  always_comb begin
    n         = '0;
    bnd.bytes = '0;
    bnd.sep   = '0;
    if (pre_pct) begin
      bnd.bytes[n] = uqpd_pkg::CH_PERCENT;
      n = n + 2'd1;
    end
    if (pre_dig) begin
      bnd.bytes[n] = held_r;
      n = n + 2'd1;
    end
    if (main_vld) begin
      bnd.bytes[n] = main_byte;
      bnd.sep[n]   = main_sep;
      n = n + 2'd1;
    end
    if (flush_pct) begin
      bnd.bytes[n] = uqpd_pkg::CH_PERCENT;
      n = n + 2'd1;
    end
    if (flush_dig) begin
      bnd.bytes[n] = held_mid;
      n = n + 2'd1;
    end
    bnd.cnt  = n;
    bnd.last = in_last;
    bnd.args = args_mid;
  end

  assign bnd_vld = (n != '0);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    args_nxt  = args_r;
    if (accept) begin
      if (in_last) begin
        phase_nxt = uqpd_pkg::PH_IDLE;
        held_nxt  = 8'h00;
        args_nxt  = uqpd_pkg::ARGS_INIT;
      end else begin
        phase_nxt = phase_mid;
        held_nxt  = held_mid;
        args_nxt  = args_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uqpd_pkg::PH_IDLE;
      held_r  <= 8'h00;
      args_r  <= uqpd_pkg::ARGS_INIT;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      args_r  <= args_nxt;
    end
  end

endmodule

/* rtl/uqpd_queue.sv */
// Bundle queue that decouples the front end from the output serializer.
module uqpd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  uqpd_pkg::res_bundle_t wr_data,
  input  logic                  rd_en,
  output uqpd_pkg::res_bundle_t rd_data,
  output logic                  rd_vld,
  output logic                  q_full
);

  uqpd_pkg::res_bundle_t mem_r [uqpd_pkg::QUEUE_DEPTH];
  logic [uqpd_pkg::QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [uqpd_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign rd_data = mem_r[rptr_r];
  assign rd_vld  = (cnt_r != '0);
  assign q_full  = (cnt_r == uqpd_pkg::QCNT_W'(uqpd_pkg::QUEUE_DEPTH));

  always_comb begin
    wptr_nxt = wr_en ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd_en ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/uqpd_back.sv */
// Back end: walk the words of the head bundle into the output register.
module uqpd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uqpd_pkg::res_bundle_t hbnd,
  input  logic                  hvld,
  output logic                  hpop,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            out_byte,
  output logic                  out_is_separator,
  output logic                  out_run_end,
  output logic                  out_string_end,
  output logic [15:0]           out_arg_count
);

  logic [uqpd_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r;
  logic        sep_r, run_r, send_r;
  logic [15:0] args_r;
  logic        take, last_slot;

  assign take      = hvld && (!vld_r || pop);
  assign last_slot = (slot_r == (hbnd.cnt - 2'd1));
  assign hpop      = take && last_slot;

  always_comb begin
    slot_nxt = slot_r;
    vld_nxt  = vld_r;
    if (take) begin
      slot_nxt = last_slot ? '0 : slot_r + 2'd1;
      vld_nxt  = 1'b1;
    end else if (pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Payload: load on each taken word, hold otherwise.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= hbnd.bytes[slot_r];
      sep_r  <= hbnd.sep[slot_r];
      run_r  <= last_slot;
      send_r <= last_slot && hbnd.last;
      args_r <= (last_slot && hbnd.last) ? hbnd.args : 16'd0;
    end
  end

  assign empty            = !vld_r;
  assign out_byte         = byte_r;
  assign out_is_separator = sep_r;
  assign out_run_end      = run_r;
  assign out_string_end   = send_r;
  assign out_arg_count    = args_r;

endmodule

/* rtl/url_query_percent_decoder_top.sv */
// Path: an accepted byte's bundle enters the bundle queue, then the output register.
// Throughput: one byte accepted per cycle while the 4-bundle queue has room; one word
//   leaves per cycle while pop keeps up, so pop sets the rate (up to 3 words a byte).
// Reset: synchronous active-low rst_n clears escape state, argument count (to 1),
//   queue pointers and the output valid flag; empty is high after reset.
module url_query_percent_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input queue side
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        push,
  output logic        full,
  // Result queue side
  output logic [7:0]  out_byte,
  output logic        out_is_separator,
  output logic        out_run_end,
  output logic        out_string_end,
  output logic [15:0] out_arg_count,
  output logic        empty,
  input  logic        pop
);

  uqpd_pkg::res_bundle_t fbnd, hbnd;
  logic fbnd_vld, accept, q_wr, hvld, hpop, q_full;

  // Accept whenever the bundle queue has room; the front end never stalls otherwise.
  assign full   = q_full;
  assign accept = push && !q_full;
  // Drop bytes that produce no word (an opening percent or first hex digit).
  assign q_wr   = accept && fbnd_vld;

  uqpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte),
    .in_last (in_last),
    .accept  (accept),
    .bnd     (fbnd),
    .bnd_vld (fbnd_vld)
  );

  // Hold bundles here so a stalled consumer does not block classification.
  uqpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (fbnd),
    .rd_en   (hpop),
    .rd_data (hbnd),
    .rd_vld  (hvld),
    .q_full  (q_full)
  );

  // Advance one word per cycle into the output register while it is empty or popped.
  uqpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .hbnd             (hbnd),
    .hvld             (hvld),
    .hpop             (hpop),
    .pop              (pop),
    .empty            (empty),
    .out_byte         (out_byte),
    .out_is_separator (out_is_separator),
    .out_run_end      (out_run_end),
    .out_string_end   (out_string_end),
    .out_arg_count    (out_arg_count)
  );

endmodule

/* rtl/uqpd_checker.sv */
// Port-level checker of the URL query percent decoder, bound to the top level.
`include "url_query_percent_decoder_top_defines.svh"

module uqpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [7:0]  in_byte,
  input logic        in_last,
  input logic        push,
  input logic        full,
  input logic [7:0]  out_byte,
  input logic        out_is_separator,
  input logic        out_run_end,
  input logic        out_string_end,
  input logic [15:0] out_arg_count,
  input logic        empty,
  input logic        pop
);

  `UQPD_ASSERT(a_hold_word, (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_string_end) && $stable(out_arg_count)), "result word changed while stalled")
  `UQPD_ASSERT(a_send_run, (!empty && out_string_end) |-> out_run_end, "string end without run end")
  `UQPD_ASSERT(a_args_zero, (!empty && !out_string_end) |-> (out_arg_count == 16'd0), "argument count off the string end")
  `UQPD_ASSERT(a_args_nz, (!empty && out_string_end) |-> (out_arg_count != 16'd0), "zero argument count at string end")
  `UQPD_ASSERT_ALWAYS(a_sep_zero, (!empty && out_is_separator) |-> (out_byte == 8'h00), "separator with nonzero byte")

endmodule

bind url_query_percent_decoder_top uqpd_checker u_uqpd_checker (.*);
